>>> rtl/poly_voice_allocator_macros.svh
// Assertion helpers used by the allocator top level.
`ifndef POLY_VOICE_ALLOCATOR_MACROS_SVH
`define POLY_VOICE_ALLOCATOR_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define PVA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pva: same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define PVA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pva: next-cycle check failed");

`endif

>>> rtl/pva_pkg.sv
`default_nettype none

package pva_pkg;

    // Number of voices and the widths that follow from it.
    localparam int unsigned NUM_VOICES = 8;
    localparam int unsigned VIDX_W     = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int unsigned TREE_LEAVES = 1 << VIDX_W;

    localparam int unsigned AGE_W  = 32;
    localparam int unsigned NOTE_W = 7;
    localparam int unsigned VEL_W  = 7;

    // Request codes.
    localparam logic [1:0] REQ_NOTE_ON  = 2'd0;
    localparam logic [1:0] REQ_NOTE_OFF = 2'd1;
    localparam logic [1:0] REQ_ALL_OFF  = 2'd2;
    localparam logic [1:0] REQ_FINISHED = 2'd3;

    // Voice stages.
    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_ATTACK  = 2'd1;
    localparam logic [1:0] ST_HELD    = 2'd2;
    localparam logic [1:0] ST_RELEASE = 2'd3;

    // Result action codes.
    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_RETRIG  = 3'd1;
    localparam logic [2:0] ACT_FREE    = 3'd2;
    localparam logic [2:0] ACT_STEAL   = 3'd3;
    localparam logic [2:0] ACT_RELEASE = 3'd4;

    typedef logic [VIDX_W-1:0]                   t_vidx;
    typedef logic [NUM_VOICES-1:0]               t_vmask;
    typedef logic [NUM_VOICES-1:0][1:0]          t_stage_vec;
    typedef logic [NUM_VOICES-1:0][NOTE_W-1:0]   t_note_vec;
    typedef logic [NUM_VOICES-1:0][AGE_W-1:0]    t_age_vec;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [NOTE_W-1:0] note_number;
        logic [VEL_W-1:0]  note_velocity;
        logic [2:0]        finished_voice;
    } t_req;

    typedef struct packed {
        logic [2:0] action_code;
        logic [2:0] voice_index;
        logic [7:0] voice_gain;
        logic [7:0] changed_mask;
    } t_rsp;

    // Outcome of the voice searches for a note on.
    typedef struct packed {
        logic  match_hit;
        t_vidx match_idx;
        logic  free_hit;
        t_vidx free_idx;
        t_vidx steal_idx;
    } t_pick;

endpackage

`default_nettype wire

>>> rtl/pva_if.sv
`default_nettype none

// Request channel into the allocator.
interface pva_req_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    req_type;
    logic [pva_pkg::NOTE_W-1:0]    note_number;
    logic [pva_pkg::VEL_W-1:0]     note_velocity;
    logic [2:0]                    finished_voice;

    modport source (
        output valid, req_type, note_number, note_velocity, finished_voice,
        input  ready
    );
    modport sink (
        input  valid, req_type, note_number, note_velocity, finished_voice,
        output ready
    );
endinterface

// Result channel out of the allocator.
interface pva_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] action_code;
    logic [2:0] voice_index;
    logic [7:0] voice_gain;
    logic [7:0] changed_mask;

    modport source (
        output valid, action_code, voice_index, voice_gain, changed_mask,
        input  ready
    );
    modport sink (
        input  valid, action_code, voice_index, voice_gain, changed_mask,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/pva_gain.sv
`default_nettype none

// Velocity to Q0.8 gain: 64 + floor((192*v + 63) / 127), saturated at 255.
// The division by 127 is a multiply by 129/2^14 followed by one correction step.
module pva_gain (
    input  wire logic [6:0] i_velocity,
    output logic      [7:0] o_gain
);

    logic [14:0] w_num;
    logic [21:0] w_prod;
    logic [7:0]  w_quot_est;
    logic [14:0] w_rem;
    logic [7:0]  w_quot;
    logic [8:0]  w_sum;

    always_comb begin
        w_num      = 15'(i_velocity) * 15'd192 + 15'd63;
        w_prod     = 22'(w_num) * 22'd129;
        w_quot_est = w_prod[21:14];
        // The estimate is the true quotient or one below it.
        w_rem      = w_num - 15'(w_quot_est) * 15'd127;
        w_quot     = w_quot_est + 8'(w_rem >= 15'd127);
        w_sum      = 9'(w_quot) + 9'd64;
        o_gain     = w_sum[8] ? 8'hFF : w_sum[7:0];
    end

endmodule

`default_nettype wire

>>> rtl/pva_select.sv
`default_nettype none

// Voice searches for a note on: lowest sounding voice with the same note,
// lowest idle voice, and the voice with the smallest age (lowest index on ties).
module pva_select (
    input  wire pva_pkg::t_stage_vec     i_stage,
    input  wire pva_pkg::t_note_vec      i_note,
    input  wire pva_pkg::t_age_vec       i_age,
    input  wire logic [pva_pkg::NOTE_W-1:0] i_req_note,
    output pva_pkg::t_pick               o_pick
);

    localparam int unsigned NODES = 2 * pva_pkg::TREE_LEAVES;

    logic [pva_pkg::AGE_W-1:0] w_tree_age [NODES];
    pva_pkg::t_vidx            w_tree_idx [NODES];

    always_comb begin
        o_pick = '0;
        // Walking downwards leaves the lowest hit in place.
        for (int i = pva_pkg::NUM_VOICES - 1; i >= 0; i--) begin
            if (i_stage[i] != pva_pkg::ST_IDLE && i_note[i] == i_req_note) begin
                o_pick.match_hit = 1'b1;
                o_pick.match_idx = pva_pkg::t_vidx'(i);
            end
            if (i_stage[i] == pva_pkg::ST_IDLE) begin
                o_pick.free_hit = 1'b1;
                o_pick.free_idx = pva_pkg::t_vidx'(i);
            end
        end

        // Tournament tree for the oldest voice. Padding leaves carry the
        // largest age and a higher index, so they never win against a voice.
        for (int n = 0; n < int'(NODES); n++) begin
            w_tree_age[n] = '1;
            w_tree_idx[n] = '0;
        end
        for (int i = 0; i < int'(pva_pkg::TREE_LEAVES); i++) begin
            w_tree_idx[pva_pkg::TREE_LEAVES + i] = pva_pkg::t_vidx'(i);
            if (i < int'(pva_pkg::NUM_VOICES)) begin
                w_tree_age[pva_pkg::TREE_LEAVES + i] = i_age[i];
            end
        end
        for (int n = int'(pva_pkg::TREE_LEAVES) - 1; n >= 1; n--) begin
            if (w_tree_age[2 * n + 1] < w_tree_age[2 * n]) begin
                w_tree_age[n] = w_tree_age[2 * n + 1];
                w_tree_idx[n] = w_tree_idx[2 * n + 1];
            end else begin
                w_tree_age[n] = w_tree_age[2 * n];
                w_tree_idx[n] = w_tree_idx[2 * n];
            end
        end
        o_pick.steal_idx = w_tree_idx[1];
    end

endmodule

`default_nettype wire

>>> rtl/poly_voice_allocator.sv
// Channel   Direction  Handshake      Carries
// i_req     in         valid/ready    req_type, note_number, note_velocity, finished_voice
// o_rsp     out        valid/ready    action_code, voice_index, voice_gain, changed_mask
//
// One request is taken per clock cycle while the input register is empty or moving on; each
// gives exactly one result, offered once it has moved from the input to the output register.
// A request waits in the input register, where the voice searches, the gain and the state
// update are worked out in a single pass, and the result lands in the output register. The
// oldest-voice compare tree over the age stamps sets the path length.
// i_rst_n is synchronous and active low: all voices go idle, ages and the age counter clear.
// When a result is held back the input register still accepts one more request.
`default_nettype none

`include "poly_voice_allocator_macros.svh"

module poly_voice_allocator (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pva_req_if.sink   i_req,
    pva_rsp_if.source o_rsp
);

    // Input register.
    logic          r_in_valid;
    pva_pkg::t_req r_in;

    // Output register.
    logic          r_out_valid;
    pva_pkg::t_rsp r_out;

    // Voice state. Notes are only read for sounding voices, so they need no reset.
    pva_pkg::t_stage_vec         r_stage, n_stage;
    pva_pkg::t_note_vec          r_note,  n_note;
    pva_pkg::t_age_vec           r_age,   n_age;
    logic [pva_pkg::AGE_W-1:0]   r_age_counter, n_age_counter;

    logic                        w_adv;
    logic                        w_accept;
    logic                        w_is_on;
    logic [7:0]                  w_gain;
    pva_pkg::t_pick              w_pick_info;
    pva_pkg::t_vidx              w_pick;
    pva_pkg::t_vidx              w_fin_idx;
    logic                        w_fin_ok;
    logic [2:0]                  w_action;
    pva_pkg::t_vmask             w_changed;
    pva_pkg::t_rsp               w_rsp;

    // The request in the input register moves on whenever the output register
    // is empty or its result is being taken in this cycle.
    assign w_adv    = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign w_accept = i_req.valid && i_req.ready;
    assign w_is_on  = (r_in.req_type == pva_pkg::REQ_NOTE_ON);

    assign i_req.ready = !r_in_valid || w_adv;

    pva_gain u_gain (
        .i_velocity (r_in.note_velocity),
        .o_gain     (w_gain)
    );

    pva_select u_select (
        .i_stage    (r_stage),
        .i_note     (r_note),
        .i_age      (r_age),
        .i_req_note (r_in.note_number),
        .o_pick     (w_pick_info)
    );

    // A finished voice beyond the configured count is ignored.
    assign w_fin_ok  = (32'(r_in.finished_voice) < 32'(pva_pkg::NUM_VOICES));
    assign w_fin_idx = pva_pkg::t_vidx'(r_in.finished_voice);

    // Retrigger beats a free voice, which beats stealing the oldest one.
    always_comb begin
        if (w_pick_info.match_hit) begin
            w_pick = w_pick_info.match_idx;
        end else if (w_pick_info.free_hit) begin
            w_pick = w_pick_info.free_idx;
        end else begin
            w_pick = w_pick_info.steal_idx;
        end
    end

    always_comb begin
        n_stage       = r_stage;
        n_note        = r_note;
        n_age         = r_age;
        n_age_counter = r_age_counter;
        w_action      = pva_pkg::ACT_NONE;

        if (w_adv) begin
            unique case (r_in.req_type)
                pva_pkg::REQ_NOTE_ON: begin
                    if (w_pick_info.match_hit) begin
                        w_action = pva_pkg::ACT_RETRIG;
                    end else if (w_pick_info.free_hit) begin
                        w_action = pva_pkg::ACT_FREE;
                    end else begin
                        w_action = pva_pkg::ACT_STEAL;
                    end
                    n_age_counter   = r_age_counter + 1'b1;
                    n_note[w_pick]  = r_in.note_number;
                    n_stage[w_pick] = pva_pkg::ST_ATTACK;
                    n_age[w_pick]   = r_age_counter + 1'b1;
                end
                pva_pkg::REQ_NOTE_OFF: begin
                    for (int i = 0; i < int'(pva_pkg::NUM_VOICES); i++) begin
                        if ((r_stage[i] == pva_pkg::ST_ATTACK ||
                             r_stage[i] == pva_pkg::ST_HELD) &&
                            r_note[i] == r_in.note_number) begin
                            n_stage[i] = pva_pkg::ST_RELEASE;
                        end
                    end
                end
                pva_pkg::REQ_ALL_OFF: begin
                    for (int i = 0; i < int'(pva_pkg::NUM_VOICES); i++) begin
                        if (r_stage[i] == pva_pkg::ST_ATTACK ||
                            r_stage[i] == pva_pkg::ST_HELD) begin
                            n_stage[i] = pva_pkg::ST_RELEASE;
                        end
                    end
                end
                pva_pkg::REQ_FINISHED: begin
                    if (w_fin_ok && r_stage[w_fin_idx] != pva_pkg::ST_IDLE) begin
                        n_stage[w_fin_idx] = pva_pkg::ST_IDLE;
                    end
                end
                default: begin
                end
            endcase
        end

        for (int i = 0; i < int'(pva_pkg::NUM_VOICES); i++) begin
            w_changed[i] = (n_stage[i] != r_stage[i]);
        end

        // Any stage change from a request other than a note on reads as a release.
        if (!w_is_on && w_changed != '0) begin
            w_action = pva_pkg::ACT_RELEASE;
        end

        w_rsp.action_code  = w_action;
        w_rsp.voice_index  = w_is_on ? 3'(w_pick) : 3'd0;
        w_rsp.voice_gain   = w_is_on ? w_gain : 8'd0;
        w_rsp.changed_mask = 8'(w_changed);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_stage       <= '0;
            r_age         <= '0;
            r_age_counter <= '0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            r_stage       <= n_stage;
            r_age         <= n_age;
            r_age_counter <= n_age_counter;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in.req_type       <= i_req.req_type;
            r_in.note_number    <= i_req.note_number;
            r_in.note_velocity  <= i_req.note_velocity;
            r_in.finished_voice <= i_req.finished_voice;
        end
        if (w_adv) begin
            r_out <= w_rsp;
        end
        r_note <= n_note;
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.action_code  = r_out.action_code;
    assign o_rsp.voice_index  = r_out.voice_index;
    assign o_rsp.voice_gain   = r_out.voice_gain;
    assign o_rsp.changed_mask = r_out.changed_mask;

    // Every allocation advances the age counter by exactly one.
    `PVA_ASSERT_NEXT(a_counter_step, i_clk, i_rst_n, w_adv && w_is_on, r_age_counter == $past(r_age_counter) + 32'd1)
    // A voice reported as free really was idle.
    `PVA_ASSERT_SAME(a_free_was_idle, i_clk, i_rst_n, w_adv && w_action == pva_pkg::ACT_FREE, r_stage[w_pick] == pva_pkg::ST_IDLE)
    // The allocated voice is in attack once the note on has gone through.
    `PVA_ASSERT_NEXT(a_pick_attack, i_clk, i_rst_n, w_adv && w_is_on, r_stage[$past(w_pick)] == pva_pkg::ST_ATTACK)
    // A result that did nothing changes no stage and carries no gain.
    `PVA_ASSERT_SAME(a_none_quiet, i_clk, i_rst_n, r_out_valid && r_out.action_code == pva_pkg::ACT_NONE, r_out.changed_mask == 8'd0 && r_out.voice_gain == 8'd0)

endmodule

`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the voice allocator. Requests go in on the request
// channel in random bursts while the result channel stalls on a pattern of its
// own. Every accepted request is run through a shadow copy of the voice state
// here, and the outcome is queued. Each result that comes out is then compared
// field by field with the oldest queued outcome.
module testbench;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned LONG_HOLD   = 60;
    localparam int unsigned DRAIN_WAIT  = 10;

    typedef logic [pva_pkg::NOTE_W-1:0] t_note_num;
    typedef logic [pva_pkg::VEL_W-1:0]  t_velocity;

    logic clk;
    logic rst_n;

    pva_req_if req_bus ();
    pva_rsp_if rsp_bus ();

    poly_voice_allocator u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    // Shadow copy of the voice state, advanced once per accepted request.
    logic [1:0]                shadow_stage [pva_pkg::NUM_VOICES];
    logic [pva_pkg::NOTE_W-1:0] shadow_note [pva_pkg::NUM_VOICES];
    logic [pva_pkg::AGE_W-1:0] shadow_age   [pva_pkg::NUM_VOICES];
    logic [7:0]                shadow_gain  [pva_pkg::NUM_VOICES];
    logic [pva_pkg::AGE_W-1:0] shadow_age_count;

    pva_pkg::t_rsp pending_results [$];
    pva_pkg::t_rsp last_prediction;
    int unsigned   fail_count;
    int unsigned   cycle_count;
    int unsigned   burst_left;
    bit            bursty;
    bit            long_hold_request;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Gain in Q0.8: 0.25 + 0.75 * v / 127, rounded to nearest, clipped at 255.
    function automatic logic [7:0] velocity_gain(logic [pva_pkg::VEL_W-1:0] vel);
        int unsigned g;
        g = 64 + (192 * int'(vel) + 63) / 127;
        return (g > 255) ? 8'd255 : 8'(g);
    endfunction

    function automatic pva_pkg::t_rsp predict_allocation(pva_pkg::t_req r);
        pva_pkg::t_rsp                  rsp;
        logic [1:0]                     prior [pva_pkg::NUM_VOICES];
        int unsigned                    pick;
        bit                             found;
        logic [pva_pkg::NUM_VOICES-1:0] diff;
        rsp   = '0;
        pick  = 0;
        found = 1'b0;
        diff  = '0;
        prior = shadow_stage;
        case (r.req_type)
            pva_pkg::REQ_NOTE_ON: begin
                rsp.voice_gain = velocity_gain(r.note_velocity);
                // A sounding voice on the same note wins, then the first idle
                // voice, and only then the voice with the oldest stamp.
                for (int i = 0; i < pva_pkg::NUM_VOICES; i++) begin
                    if (!found && shadow_stage[i] != pva_pkg::ST_IDLE &&
                            shadow_note[i] == r.note_number) begin
                        pick = i;
                        found = 1'b1;
                        rsp.action_code = pva_pkg::ACT_RETRIG;
                    end
                end
                for (int i = 0; i < pva_pkg::NUM_VOICES; i++) begin
                    if (!found && shadow_stage[i] == pva_pkg::ST_IDLE) begin
                        pick = i;
                        found = 1'b1;
                        rsp.action_code = pva_pkg::ACT_FREE;
                    end
                end
                if (!found) begin
                    for (int i = 1; i < pva_pkg::NUM_VOICES; i++) begin
                        if (shadow_age[i] < shadow_age[pick]) begin
                            pick = i;
                        end
                    end
                    rsp.action_code = pva_pkg::ACT_STEAL;
                end
                shadow_age_count   = shadow_age_count + 1'b1;
                shadow_note[pick]  = r.note_number;
                shadow_gain[pick]  = rsp.voice_gain;
                shadow_stage[pick] = pva_pkg::ST_ATTACK;
                shadow_age[pick]   = shadow_age_count;
                rsp.voice_index    = 3'(pick);
            end
            pva_pkg::REQ_NOTE_OFF: begin
                for (int i = 0; i < pva_pkg::NUM_VOICES; i++) begin
                    if ((shadow_stage[i] == pva_pkg::ST_ATTACK ||
                            shadow_stage[i] == pva_pkg::ST_HELD) &&
                            shadow_note[i] == r.note_number) begin
                        shadow_stage[i] = pva_pkg::ST_RELEASE;
                    end
                end
            end
            pva_pkg::REQ_ALL_OFF: begin
                for (int i = 0; i < pva_pkg::NUM_VOICES; i++) begin
                    if (shadow_stage[i] == pva_pkg::ST_ATTACK ||
                            shadow_stage[i] == pva_pkg::ST_HELD) begin
                        shadow_stage[i] = pva_pkg::ST_RELEASE;
                    end
                end
            end
            pva_pkg::REQ_FINISHED: begin
                if (r.finished_voice < pva_pkg::NUM_VOICES &&
                        shadow_stage[r.finished_voice] != pva_pkg::ST_IDLE) begin
                    shadow_stage[r.finished_voice] = pva_pkg::ST_IDLE;
                end
            end
        endcase
        for (int i = 0; i < pva_pkg::NUM_VOICES; i++) begin
            diff[i] = (shadow_stage[i] != prior[i]);
        end
        rsp.changed_mask = 8'(diff);
        if (r.req_type != pva_pkg::REQ_NOTE_ON && diff != '0) begin
            rsp.action_code = pva_pkg::ACT_RELEASE;
        end
        return rsp;
    endfunction

    function automatic pva_pkg::t_req make_request(logic [1:0] kind, int unsigned note,
                                                   int unsigned vel, int unsigned voice);
        pva_pkg::t_req r;
        r.req_type       = kind;
        r.note_number    = t_note_num'(note);
        r.note_velocity  = t_velocity'(vel);
        r.finished_voice = 3'(voice);
        return r;
    endfunction

    // Most notes come from one octave so that retriggers and note offs find
    // their voice; the rest spread over the whole range.
    function automatic pva_pkg::t_req random_request(int unsigned on_weight);
        pva_pkg::t_req r;
        int unsigned   roll;
        roll = $urandom_range(0, 99);
        r.note_number    = ($urandom_range(0, 9) < 7) ? t_note_num'($urandom_range(56, 67))
                                                      : t_note_num'($urandom());
        r.note_velocity  = t_velocity'($urandom());
        r.finished_voice = 3'($urandom());
        if (roll >= 96) begin
            r.req_type = pva_pkg::REQ_ALL_OFF;
        end else if (roll < on_weight) begin
            r.req_type = pva_pkg::REQ_NOTE_ON;
        end else if (roll < on_weight + (96 - on_weight) / 2) begin
            r.req_type = pva_pkg::REQ_NOTE_OFF;
        end else begin
            r.req_type = pva_pkg::REQ_FINISHED;
        end
        return r;
    endfunction

    // Entered and left at a falling edge. Valid stays high on the way out so
    // that back-to-back requests need no second assignment in one step.
    task automatic send_request(input pva_pkg::t_req r);
        int unsigned gap;
        if (bursty && burst_left == 0) begin
            gap        = $urandom_range(0, 8);
            burst_left = $urandom_range(1, 16);
            if (gap != 0) begin
                req_bus.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        req_bus.valid          <= 1'b1;
        req_bus.req_type       <= r.req_type;
        req_bus.note_number    <= r.note_number;
        req_bus.note_velocity  <= r.note_velocity;
        req_bus.finished_voice <= r.finished_voice;
        do @(posedge clk); while (req_bus.ready !== 1'b1);
        last_prediction = predict_allocation(r);
        pending_results.push_back(last_prediction);
        if (burst_left != 0) begin
            burst_left--;
        end
        @(negedge clk);
    endtask

    task automatic test_fill_and_steal();
        // Eight fresh notes take the voices in order, the extreme velocities
        // first; two more then steal the two oldest voices.
        for (int i = 0; i < pva_pkg::NUM_VOICES; i++) begin
            send_request(make_request(pva_pkg::REQ_NOTE_ON, 60 + i,
                                      (i == 0) ? 0 : (i == 1) ? 127 : $urandom_range(0, 127),
                                      $urandom_range(0, 7)));
        end
        send_request(make_request(pva_pkg::REQ_NOTE_ON, 127, 64, 0));
        send_request(make_request(pva_pkg::REQ_NOTE_ON, 0, 1, 7));
    endtask

    task automatic test_retrigger();
        // Retrigger while in attack leaves the stage alone; from release it
        // moves the voice back to attack.
        send_request(make_request(pva_pkg::REQ_NOTE_ON, 62, 100, 0));
        send_request(make_request(pva_pkg::REQ_NOTE_OFF, 62, 0, 0));
        send_request(make_request(pva_pkg::REQ_NOTE_ON, 62, 33, 0));
    endtask

    task automatic test_release_paths();
        send_request(make_request(pva_pkg::REQ_NOTE_OFF, 100, 0, 0));
        send_request(make_request(pva_pkg::REQ_NOTE_OFF, 63, 0, 0));
        send_request(make_request(pva_pkg::REQ_NOTE_OFF, 63, 0, 0));
        send_request(make_request(pva_pkg::REQ_ALL_OFF, 0, 0, 0));
        send_request(make_request(pva_pkg::REQ_ALL_OFF, 127, 127, 7));
        send_request(make_request(pva_pkg::REQ_FINISHED, 0, 0, 3));
        send_request(make_request(pva_pkg::REQ_FINISHED, 0, 0, 3));
        send_request(make_request(pva_pkg::REQ_NOTE_ON, 90, 127, 0));
        send_request(make_request(pva_pkg::REQ_FINISHED, 0, 0, 3));
    endtask

    task automatic test_output_backpressure();
        // The result side holds off while requests keep coming back to back,
        // so the pipeline fills and the request side has to stall.
        long_hold_request = 1'b1;
        bursty = 1'b0;
        repeat (16) begin
            send_request(random_request(60));
        end
        bursty = 1'b1;
    endtask

    task automatic test_random_traffic(int unsigned target);
        int unsigned sent;
        int unsigned on_weight;
        sent      = 0;
        on_weight = 50;
        while (sent < target) begin
            if (sent % 64 == 0) begin
                on_weight = $urandom_range(25, 70);
            end
            send_request(random_request(on_weight));
            sent++;
        end
    endtask

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            fail_count++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    always @(posedge clk) begin
        pva_pkg::t_rsp want;
        if (rst_n && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                fail_count++;
                $error("result arrived with no request outstanding");
            end else begin
                want = pending_results.pop_front();
                check_field("action_code", want.action_code, rsp_bus.action_code);
                check_field("voice_index", want.voice_index, rsp_bus.voice_index);
                check_field("voice_gain", want.voice_gain, rsp_bus.voice_gain);
                check_field("changed_mask", want.changed_mask, rsp_bus.changed_mask);
            end
        end
    end

    // Result-side stall pattern: stretches of always ready, random ready and
    // mostly stalled, with a long hold-off when one is requested.
    initial begin
        int unsigned hold_left;
        int unsigned stretch_left;
        int unsigned mode;
        hold_left     = 0;
        stretch_left  = 0;
        mode          = 0;
        rsp_bus.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (long_hold_request) begin
                long_hold_request = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left != 0) begin
                hold_left--;
                rsp_bus.ready <= 1'b0;
            end else begin
                if (stretch_left == 0) begin
                    mode = $urandom_range(0, 2);
                    stretch_left = $urandom_range(4, 40);
                end
                stretch_left--;
                case (mode)
                    0:       rsp_bus.ready <= 1'b1;
                    1:       rsp_bus.ready <= 1'($urandom_range(0, 1));
                    default: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        fail_count        = 0;
        cycle_count       = 0;
        burst_left        = 0;
        bursty            = 1'b1;
        long_hold_request = 1'b0;
        shadow_age_count  = '0;
        for (int i = 0; i < pva_pkg::NUM_VOICES; i++) begin
            shadow_stage[i] = pva_pkg::ST_IDLE;
            shadow_note[i]  = '0;
            shadow_age[i]   = '0;
            shadow_gain[i]  = '0;
        end
        rst_n                  = 1'b0;
        req_bus.valid          = 1'b0;
        req_bus.req_type       = pva_pkg::REQ_NOTE_ON;
        req_bus.note_number    = '0;
        req_bus.note_velocity  = '0;
        req_bus.finished_voice = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_fill_and_steal();
        test_retrigger();
        test_release_paths();
        test_output_backpressure();
        test_random_traffic(912);

        req_bus.valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
